// ----- sv/evg_pkg.sv -----
// Types and constants shared by the event group waiter and wake block.
`default_nettype none

package evg_pkg;

  localparam int unsigned FLAG_W = 8;
  localparam int unsigned TASK_W = 6;
  localparam int unsigned BIDX_W = 4;
  localparam int unsigned KIND_W = 2;

  localparam logic [KIND_W-1:0] KIND_QUEUED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROPPED  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WOKEN    = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SET_DONE = 2'd3;

  localparam logic OP_WAIT = 1'b0;
  localparam logic OP_SET  = 1'b1;

  typedef struct packed {
    logic [TASK_W-1:0] task_id;
    logic [FLAG_W-1:0] mask;
    logic              all_mode;
  } evg_entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PACK
  } evg_state_t;

endpackage

`default_nettype wire

// ----- sv/evg_table_mem.sv -----
// Waiter table storage: one write port and one read port with registered read data.
`default_nettype none

module evg_table_mem #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire                  clk,
  input  wire                  we,
  input  wire [AW-1:0]         waddr,
  input  evg_pkg::evg_entry_t  wdata,
  input  wire                  re,
  input  wire [AW-1:0]         raddr,
  output evg_pkg::evg_entry_t  rdata
);
  import evg_pkg::*;

  evg_entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/event_group_waiter_wake.sv -----
// Event group: flag register, waiter table sequencer and result generation.
//
//   Channel   Handshake              Beat fields
//   command   start high, busy low   operation task_id wait_mask wait_all bit_index bit_value
//   result    strobe (one cycle)     kind woken_task event_bits last
//
// A wait command gives one result on the next cycle.
// A set command with a bit index of 8 or more, or with an empty table, also gives its one result on the next cycle.
// Otherwise the table is scanned newest first, one entry a cycle through the memory read
// port, and if any task woke, a second pass packs the survivors.
// Reset clears the flags and empties the table at once. Results cannot be stalled.
`default_nettype none

module event_group_waiter_wake #(
  parameter int unsigned MAX_WAITERS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  output logic                         busy,
  input  wire                          operation,
  input  wire [evg_pkg::TASK_W-1:0]    task_id,
  input  wire [evg_pkg::FLAG_W-1:0]    wait_mask,
  input  wire                          wait_all,
  input  wire [evg_pkg::BIDX_W-1:0]    bit_index,
  input  wire                          bit_value,
  output logic                         strobe,
  output logic [evg_pkg::KIND_W-1:0]   kind,
  output logic [evg_pkg::TASK_W-1:0]   woken_task,
  output logic [evg_pkg::FLAG_W-1:0]   event_bits,
  output logic                         last
);
  import evg_pkg::*;

  localparam int unsigned AW = $clog2(MAX_WAITERS);
  localparam int unsigned CW = $clog2(MAX_WAITERS + 1);

  evg_state_t state, state_next;

  logic [CW-1:0]          count, count_next;
  logic [FLAG_W-1:0]      flags, flags_next;
  logic [CW-1:0]          ptr, ptr_next;
  logic [CW-1:0]          wptr, wptr_next;
  logic [MAX_WAITERS-1:0] keep, keep_next;
  logic                   any_woke, any_woke_next;

  logic                   strobe_next;
  logic [KIND_W-1:0]      kind_next;
  logic [TASK_W-1:0]      woken_task_next;
  logic [FLAG_W-1:0]      event_bits_next;
  logic                   last_next;

  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  evg_entry_t             mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  evg_entry_t             mem_rdata;

  logic                   accept;
  logic                   full;
  logic [CW-1:0]          count_m1;
  logic [FLAG_W-1:0]      set_flags;
  logic [FLAG_W-1:0]      hit;
  logic                   met;

  evg_table_mem #(
    .DEPTH (MAX_WAITERS),
    .AW    (AW)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;
  assign full      = (count == CW'(MAX_WAITERS));
  assign count_m1  = count - CW'(1);
  assign set_flags = bit_value ? (flags | (FLAG_W'(1) << bit_index[2:0]))
                               : (flags & ~(FLAG_W'(1) << bit_index[2:0]));
  assign hit       = flags & mem_rdata.mask;
  assign met       = mem_rdata.all_mode ? (hit == mem_rdata.mask) : (hit != '0);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && operation == OP_SET && !bit_index[3] && count != '0) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr == '0) begin
          state_next = (any_woke || met) ? ST_PACK : ST_IDLE;
        end
      end
      ST_PACK: begin
        if (ptr == count_m1) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next      = count;
    flags_next      = flags;
    ptr_next        = ptr;
    wptr_next       = wptr;
    keep_next       = keep;
    any_woke_next   = any_woke;
    strobe_next     = 1'b0;
    kind_next       = KIND_SET_DONE;
    woken_task_next = '0;
    event_bits_next = flags;
    last_next       = 1'b1;
    mem_we          = 1'b0;
    mem_waddr       = count[AW-1:0];
    mem_wdata       = '{task_id: task_id, mask: wait_mask, all_mode: wait_all};
    mem_re          = 1'b0;
    mem_raddr       = count_m1[AW-1:0];
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          strobe_next = 1'b1;
          if (operation == OP_WAIT) begin
            if (full) begin
              kind_next = KIND_DROPPED;
            end else begin
              mem_we          = 1'b1;
              count_next      = count + CW'(1);
              kind_next       = KIND_QUEUED;
              woken_task_next = task_id;
            end
          end else if (!bit_index[3]) begin
            flags_next      = set_flags;
            event_bits_next = set_flags;
            if (count != '0) begin
              strobe_next   = 1'b0;
              mem_re        = 1'b1;
              ptr_next      = count_m1;
              any_woke_next = 1'b0;
            end
          end
        end
      end
      ST_SCAN: begin
        keep_next[ptr[AW-1:0]] = !met;
        if (met) begin
          strobe_next     = 1'b1;
          kind_next       = KIND_WOKEN;
          woken_task_next = mem_rdata.task_id;
          last_next       = 1'b0;
          any_woke_next   = 1'b1;
        end
        if (ptr == '0) begin
          if (any_woke || met) begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            wptr_next = '0;
          end else begin
            strobe_next = 1'b1;
          end
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr - CW'(1));
          ptr_next  = ptr - CW'(1);
        end
      end
      ST_PACK: begin
        mem_waddr = wptr[AW-1:0];
        mem_wdata = mem_rdata;
        if (keep[ptr[AW-1:0]]) begin
          mem_we    = 1'b1;
          wptr_next = wptr + CW'(1);
        end
        if (ptr == count_m1) begin
          count_next  = wptr_next;
          strobe_next = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(ptr + CW'(1));
          ptr_next  = ptr + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      flags  <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      flags  <= flags_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr        <= ptr_next;
    wptr       <= wptr_next;
    keep       <= keep_next;
    any_woke   <= any_woke_next;
    kind       <= kind_next;
    woken_task <= woken_task_next;
    event_bits <= event_bits_next;
    last       <= last_next;
  end

endmodule

`default_nettype wire

// ----- test/tb_top.sv -----
// Self-checking testbench for the event group waiter and wake block.
module tb_top;
  import evg_pkg::*;

  localparam int MAX_W = 16;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic              op;
    logic [TASK_W-1:0] tid;
    logic [FLAG_W-1:0] mask;
    logic              need_all;
    logic [BIDX_W-1:0] idx;
    logic              val;
    logic              typed;
    logic [KIND_W-1:0] t_kind;
    logic [TASK_W-1:0] t_tid;
    logic [FLAG_W-1:0] t_bits;
  } evg_cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] tid;
    logic [FLAG_W-1:0] bits;
    logic              last;
  } wake_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic operation = 1'b0;
  logic [TASK_W-1:0] task_id = '0;
  logic [FLAG_W-1:0] wait_mask = '0;
  logic wait_all = 1'b0;
  logic [BIDX_W-1:0] bit_index = '0;
  logic bit_value = 1'b0;
  logic busy;
  logic strobe;
  logic [KIND_W-1:0] kind;
  logic [TASK_W-1:0] woken_task;
  logic [FLAG_W-1:0] event_bits;
  logic last;

  logic [FLAG_W-1:0] flag_reg = '0;
  evg_entry_t waiters [MAX_W];
  int waiter_count = 0;
  wake_result_t step_results[$];
  wake_result_t awaited[$];
  wake_result_t want;
  int mismatches = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;

  event_group_waiter_wake #(.MAX_WAITERS(MAX_W)) dut (
    .clk, .rst, .start, .busy, .operation, .task_id, .wait_mask, .wait_all,
    .bit_index, .bit_value, .strobe, .kind, .woken_task, .event_bits, .last
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void push_result(input logic [KIND_W-1:0] k,
                                      input logic [TASK_W-1:0] t, input logic l);
    step_results.push_back(wake_result_t'{k, t, flag_reg, l});
  endfunction

  // Wakes are scanned newest first; a woken entry is removed and the rest close up.
  function automatic void predict_step(input evg_cmd_t c);
    int p;
    int i;
    logic [FLAG_W-1:0] hit;
    bit met;
    step_results.delete();
    if (c.op == OP_WAIT) begin
      if (waiter_count >= MAX_W) begin
        push_result(KIND_DROPPED, '0, 1'b1);
      end else begin
        waiters[waiter_count] = '{task_id: c.tid, mask: c.mask, all_mode: c.need_all};
        waiter_count++;
        push_result(KIND_QUEUED, c.tid, 1'b1);
      end
    end else begin
      if (c.idx < FLAG_W) begin
        flag_reg[c.idx[2:0]] = c.val;
        for (p = waiter_count - 1; p >= 0; p--) begin
          hit = flag_reg & waiters[p].mask;
          met = waiters[p].all_mode ? (hit == waiters[p].mask) : (hit != '0);
          if (met) begin
            push_result(KIND_WOKEN, waiters[p].task_id, 1'b0);
            for (i = p; i < waiter_count - 1; i++) waiters[i] = waiters[i + 1];
            waiter_count--;
          end
        end
      end
      push_result(KIND_SET_DONE, '0, 1'b1);
    end
  endfunction

  function automatic evg_cmd_t random_cmd(input bit fill_phase);
    evg_cmd_t c;
    c = '0;
    c.op = ($urandom_range(99) < (fill_phase ? 25 : 70)) ? OP_SET : OP_WAIT;
    c.tid = TASK_W'($urandom);
    c.need_all = 1'($urandom);
    c.val = ($urandom_range(99) < 65);
    case ($urandom_range(5))
      0: c.mask = '0;
      1: c.mask = '1;
      2: c.mask = 8'h01 << $urandom_range(7);
      3: c.mask = FLAG_W'($urandom);
      default: c.mask = FLAG_W'($urandom & $urandom);
    endcase
    c.idx = ($urandom_range(99) < 15) ? BIDX_W'($urandom_range(15, 8))
                                       : BIDX_W'($urandom_range(7));
    return c;
  endfunction

  function automatic void flag_mismatch(input string field, input int exp_v, input int got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch on %s at cycle %0d: expected %0d, got %0d",
               field, cycle_count, exp_v, got_v);
  endfunction

  task automatic issue(input evg_cmd_t c);
    while (idle_on && $urandom_range(99) < 22) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    operation <= c.op;
    task_id <= c.tid;
    wait_mask <= c.mask;
    wait_all <= c.need_all;
    bit_index <= c.idx;
    bit_value <= c.val;
    do @(posedge clk); while (busy);
    predict_step(c);
    if (c.typed)
      awaited.push_back(wake_result_t'{c.t_kind, c.t_tid, c.t_bits, 1'b1});
    else
      foreach (step_results[i]) awaited.push_back(step_results[i]);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (awaited.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else if (!rst && strobe) begin
      if (awaited.size() == 0) begin
        flag_mismatch("unexpected beat kind", -1, kind);
      end else begin
        want = awaited.pop_front();
        if (kind !== want.kind) flag_mismatch("kind", want.kind, kind);
        if (woken_task !== want.tid) flag_mismatch("woken_task", want.tid, woken_task);
        if (event_bits !== want.bits) flag_mismatch("event_bits", want.bits, event_bits);
        if (last !== want.last) flag_mismatch("last", want.last, last);
      end
    end
  end

  initial begin
    evg_cmd_t dir_rows [25];
    int k;
    dir_rows = '{
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd3,  1'b1, 1'b1, KIND_SET_DONE, 6'd0,  8'h08},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd15, 1'b1, 1'b1, KIND_SET_DONE, 6'd0,  8'h08},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd8,  1'b0, 1'b1, KIND_SET_DONE, 6'd0,  8'h08},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd3,  1'b0, 1'b1, KIND_SET_DONE, 6'd0,  8'h00},
      '{OP_WAIT, 6'd63, 8'hFF, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd63, 8'h00},
      '{OP_WAIT, 6'd0,  8'h00, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd0,  8'h00},
      '{OP_WAIT, 6'd5,  8'h00, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd5,  8'h00},
      '{OP_WAIT, 6'd9,  8'h81, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd9,  8'h00},
      '{OP_WAIT, 6'd10, 8'h03, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd10, 8'h00},
      '{OP_WAIT, 6'd17, 8'h40, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd17, 8'h00},
      '{OP_WAIT, 6'd18, 8'h40, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd18, 8'h00},
      '{OP_WAIT, 6'd20, 8'h0F, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd20, 8'h00},
      '{OP_WAIT, 6'd21, 8'hF0, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd21, 8'h00},
      '{OP_WAIT, 6'd33, 8'h01, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd33, 8'h00},
      '{OP_WAIT, 6'd34, 8'h02, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd34, 8'h00},
      '{OP_WAIT, 6'd40, 8'h80, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd40, 8'h00},
      '{OP_WAIT, 6'd41, 8'hC0, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd41, 8'h00},
      '{OP_WAIT, 6'd50, 8'h3C, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd50, 8'h00},
      '{OP_WAIT, 6'd62, 8'hFE, 1'b1, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd62, 8'h00},
      '{OP_WAIT, 6'd1,  8'h7F, 1'b0, 4'd0,  1'b0, 1'b1, KIND_QUEUED,   6'd1,  8'h00},
      '{OP_WAIT, 6'd42, 8'h55, 1'b1, 4'd0,  1'b0, 1'b1, KIND_DROPPED,  6'd0,  8'h00},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd12, 1'b1, 1'b1, KIND_SET_DONE, 6'd0,  8'h00},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd7,  1'b1, 1'b0, KIND_QUEUED,   6'd0,  8'h00},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd0,  1'b1, 1'b0, KIND_QUEUED,   6'd0,  8'h00},
      '{OP_SET,  6'd0,  8'h00, 1'b0, 4'd1,  1'b1, 1'b0, KIND_QUEUED,   6'd0,  8'h00}
    };
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (k = 0; k < 25; k++) issue(dir_rows[k]);
    settle();
    // Alternate phases that favour filling the table and emptying it again.
    for (k = 0; k < 85; k++) begin
      idle_on = !(k >= 40 && k < 75);
      if (k == 56) settle();
      issue(random_cmd((k / 18) % 2 == 0));
    end
    settle();
    if (mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/evg_pkg.sv
sv/evg_table_mem.sv
sv/event_group_waiter_wake.sv
test/tb_top.sv
